[hw/rtl/kmq_pkg.sv]
// Package for the keyed multi-queue manager: sizes, codes, payload structs
// and the sequencer state type. Has no dependencies of its own.
`timescale 1ns / 1ps

package kmq_pkg;

  // Pool and queue sizing.
  localparam int POOL_ENTRIES = 64;
  localparam int WINDOWS      = 4;
  localparam int NUM_WIN_REGS = 4;

  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int PTR_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
  localparam int SLOT_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int WIN_W      = 16;
  localparam int PID_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int QLEN_W     = 7;
  localparam int WIU_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NREG_IDX_W = 2;

  // Pointer value that marks an empty list.
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_NUM0 = 3'd1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [WIN_W-1:0] window_number;
    logic [PID_W-1:0] person_id;
  } kmq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    served_id;
    logic [QLEN_W-1:0]   queue_length;
  } kmq_out_t;

  typedef enum logic {
    S_IDLE,
    S_FIN
  } kmq_state_t;

endpackage

[hw/rtl/kmq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the entry payload and link stores.
`timescale 1ns / 1ps

module kmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/keyed_multi_queue_manager.sv]
// Top level of the keyed multi-queue manager: window lookup, list sequencer
// and result register. Depends on kmq_pkg and kmq_ram.
`timescale 1ns / 1ps

// Use of the block
// Up to WINDOWS FIFO queues, each owned by a configured window number, share
// a pool of POOL_ENTRIES entries held as linked lists with a free list.
// Channels: in_* carries one command item (enqueue, serve, close), out_*
// returns one result item per command, cfg_* writes the window count and the
// window numbers (ready whenever out of reset; write only while no command is
// in flight).
// Each command is accepted in S_IDLE, where the window is looked up and the
// link and payload memories are read and written as the command needs; in
// S_FIN the read data returns, any second link write is made and the result
// is loaded into the output register. The single write port of the link
// memory is why no new item is taken until the last one leaves S_FIN.
// A finished result waits in the output register while the next item is
// accepted; if the receiver still stalls when that item finishes, the block
// holds it in S_FIN until the register is free.
// Reset empties all queues and the free list, clears the window count and
// window numbers and drops any pending result. No item or register write is
// taken while reset is held. No clearing pass is needed.
module keyed_multi_queue_manager
  import kmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  kmq_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kmq_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kmq_state_t state_r, state_nxt;

  logic [WIU_W-1:0] win_use_r;
  logic [WIN_W-1:0] win_num_r [NUM_WIN_REGS];

  logic [PTR_W-1:0] head_r  [WINDOWS];
  logic [IDX_W-1:0] tail_r  [WINDOWS];
  logic [CNT_W-1:0] count_r [WINDOWS];
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;

  // Command held from acceptance until S_FIN.
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic              hit_r;
  logic              ok_r;
  logic              from_free_r;
  logic [IDX_W-1:0]  entry_r;

  logic     out_valid_r, out_valid_nxt;
  kmq_out_t out_data_r, out_data_nxt;

  logic              accept;
  logic              fin_go;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [PTR_W-1:0]  q_head;
  logic [IDX_W-1:0]  q_tail;
  logic [CNT_W-1:0]  q_count;
  logic              from_free;
  logic              fresh_ok;
  logic [IDX_W-1:0]  alloc_e;
  logic              op_ok;

  logic [PTR_W-1:0] cur_head;
  logic [CNT_W-1:0] cur_count;
  logic [PTR_W-1:0] q_head_nxt;
  logic [IDX_W-1:0] q_tail_nxt;
  logic [CNT_W-1:0] q_count_nxt;

  logic             pay_we;
  logic [PID_W-1:0] pay_rdata;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [PTR_W-1:0] link_wdata;
  logic [IDX_W-1:0] link_raddr;
  logic [PTR_W-1:0] link_rdata;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_use_r <= '0;
      for (int i = 0; i < NUM_WIN_REGS; i++) begin
        win_num_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIN_USE) begin
        win_use_r <= cfg_data[WIU_W-1:0];
      end else if (cfg_index >= CFG_WIN_NUM0 &&
                   cfg_index < CFG_WIN_NUM0 + CFG_IDX_W'(NUM_WIN_REGS)) begin
        win_num_r[NREG_IDX_W'(cfg_index - CFG_WIN_NUM0)] <= cfg_data[WIN_W-1:0];
      end
    end
  end

  // Window lookup: the lowest valid slot with a matching number wins.
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = WINDOWS - 1; i >= 0; i--) begin
      if (WIU_W'(i) < win_use_r && win_num_r[i] == in_data.window_number) begin
        hit  = 1'b1;
        slot = SLOT_W'(i);
      end
    end
  end

  assign q_head  = head_r[slot];
  assign q_tail  = tail_r[slot];
  assign q_count = count_r[slot];

  // Entry allocation: free list first, then never-used entries.
  assign from_free = free_head_r < NULL_PTR;
  assign fresh_ok  = fresh_r < CNT_W'(POOL_ENTRIES);
  assign alloc_e   = from_free ? free_head_r[IDX_W-1:0] : fresh_r[IDX_W-1:0];

  // Whether the command changes the lists.
  always_comb begin
    case (in_data.cmd) inside
      CMD_ENQUEUE: op_ok = hit && (from_free || fresh_ok);
      CMD_SERVE, CMD_CLOSE: op_ok = hit && q_count != '0 && q_head < NULL_PTR;
      default: op_ok = 1'b0;
    endcase
  end

  // Payload memory: written by enqueue, read at the queue head.
  assign pay_we = accept && in_data.cmd == CMD_ENQUEUE && op_ok;

  kmq_ram #(
    .WIDTH(PID_W),
    .DEPTH(POOL_ENTRIES)
  ) u_payload_ram (
    .clk  (clk),
    .we   (pay_we),
    .waddr(alloc_e),
    .wdata(in_data.person_id),
    .re   (accept),
    .raddr(q_head[IDX_W-1:0]),
    .rdata(pay_rdata)
  );

  // Link memory port: first write in the accept cycle, second in S_FIN.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = q_tail;
    link_wdata = free_head_r;
    if (accept && op_ok) begin
      if (in_data.cmd == CMD_ENQUEUE) begin
        link_we    = (q_count != '0);
        link_wdata = PTR_W'(alloc_e);
      end else if (in_data.cmd == CMD_CLOSE) begin
        link_we    = 1'b1;
      end
    end else if (fin_go && hit_r && ok_r) begin
      link_waddr = entry_r;
      if (cmd_r == CMD_ENQUEUE) begin
        link_we    = 1'b1;
        link_wdata = NULL_PTR;
      end else if (cmd_r == CMD_SERVE) begin
        link_we    = 1'b1;
        link_wdata = free_head_r;
      end
    end
  end

  assign link_raddr = (in_data.cmd == CMD_ENQUEUE) ? free_head_r[IDX_W-1:0]
                                                   : q_head[IDX_W-1:0];

  kmq_ram #(
    .WIDTH(PTR_W),
    .DEPTH(POOL_ENTRIES)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (accept),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // Capture the command in the accept cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_data.cmd;
      slot_r      <= slot;
      hit_r       <= hit;
      ok_r        <= op_ok;
      from_free_r <= from_free;
      entry_r     <= (in_data.cmd == CMD_ENQUEUE) ? alloc_e : q_head[IDX_W-1:0];
    end
  end

  assign cur_head  = head_r[slot_r];
  assign cur_count = count_r[slot_r];

  // S_FIN: queue and free-list update and the result item.
  always_comb begin
    q_head_nxt    = cur_head;
    q_tail_nxt    = tail_r[slot_r];
    q_count_nxt   = cur_count;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    state_nxt     = state_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt                 = S_IDLE;
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = ST_OK;
          out_data_nxt.served_id    = '0;
          if (hit_r) begin
            case (cmd_r)
              CMD_ENQUEUE: begin
                if (ok_r) begin
                  if (from_free_r) begin
                    free_head_nxt = link_rdata;
                  end else begin
                    fresh_nxt = fresh_r + 1'b1;
                  end
                  if (cur_count == '0) begin
                    q_head_nxt = PTR_W'(entry_r);
                  end
                  q_tail_nxt  = entry_r;
                  q_count_nxt = cur_count + 1'b1;
                end else begin
                  out_data_nxt.status = ST_FULL;
                end
              end
              CMD_SERVE: begin
                if (ok_r) begin
                  out_data_nxt.served_id = pay_rdata;
                  q_count_nxt   = cur_count - 1'b1;
                  q_head_nxt    = (q_count_nxt == '0) ? NULL_PTR : link_rdata;
                  free_head_nxt = PTR_W'(entry_r);
                end else begin
                  out_data_nxt.status = ST_EMPTY;
                end
              end
              CMD_CLOSE: begin
                if (ok_r) begin
                  free_head_nxt = cur_head;
                end
                q_head_nxt  = NULL_PTR;
                q_count_nxt = '0;
              end
              default: begin
              end
            endcase
            out_data_nxt.queue_length = QLEN_W'(q_count_nxt);
          end else begin
            out_data_nxt.status       = ST_UNKNOWN;
            out_data_nxt.queue_length = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and list state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= NULL_PTR;
      fresh_r     <= '0;
      for (int i = 0; i < WINDOWS; i++) begin
        head_r[i]  <= NULL_PTR;
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      if (fin_go && hit_r) begin
        head_r[slot_r]  <= q_head_nxt;
        count_r[slot_r] <= q_count_nxt;
      end
    end
  end

  // Tail pointers and result payload need no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (fin_go && hit_r) begin
      tail_r[slot_r] <= q_tail_nxt;
    end
  end

endmodule
